// ----- hdl/crc8fp_pkg.sv -----
// Shared types, codes and the CRC-8 byte step for the frame parser.
package crc8fp_pkg;

	// Field widths fixed by the frame format
	localparam int LEN_W = 6;
	localparam logic [LEN_W-1:0] HDR_BYTES = 6'd4;

	// Header byte positions within the header
	localparam logic [1:0] HDR_SRC = 2'd0;
	localparam logic [1:0] HDR_TGT = 2'd1;
	localparam logic [1:0] HDR_CMD = 2'd2;

	localparam logic [7:0] CRC_POLY   = 8'h31;
	localparam logic [7:0] SYNC_RESET = 8'hAA;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_DATA   = 3'd2,
		PH_CRC    = 3'd3,
		PH_ERROR  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FRAME = 2'd1,
		ST_ERR   = 2'd2,
		ST_DATA  = 2'd3
	} status_t;

	typedef enum logic {
		OP_FEED  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RO_RUN  = 2'd0,
		RO_REQ  = 2'd1,
		RO_WAIT = 2'd2
	} ro_state_t;

	// Result of one accepted request, as the parser produces it
	typedef struct packed {
		status_t          status;
		logic [7:0]       source_id;
		logic [7:0]       dest_id;
		logic [7:0]       command;
		logic [LEN_W-1:0] payload_len;
		logic             last;
	} hdr_t;

	// One item in the output register
	typedef struct packed {
		status_t          status;
		logic [7:0]       source_id;
		logic [7:0]       dest_id;
		logic [7:0]       command;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       data_byte;
		logic             last;
	} out_item_t;

	// CRC-8, MSB first, no reflection, one byte per call
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hdl/crc8_frame_parser_top.sv -----
// Top level of the sync/header/length/CRC-8 frame parser.
//
//  channel  dir  signals                         contents
//  s_       in   s_tvalid s_tready s_tdata[7:0]  rx_byte; s_tuser[0] operation
//  m_       out  m_tvalid m_tready m_tdata[39:0] results; m_tuser status; m_tlast last
//  cfg_     in   cfg_valid cfg_ready cfg_data    sync_byte register write
//
//  Every accepted byte or clear request yields one result into the output register.
//  A good frame with a payload adds its payload readout: each byte is read from the payload RAM,
//  then loaded into the output register; no request is taken meanwhile.
//  Reset is asynchronous and active low; sync_byte resets to 0xAA, the RAM is not cleared.
//  A stalled output holds its item; s_tready drops until the output register can take more.
module crc8_frame_parser_top import crc8fp_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] source_id, [15:8] dest_id, [23:16] command,
	                               // [29:24] payload_len, [37:30] data_byte, [39:38] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // [7:0] sync_byte
);

	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic              accept;
	logic [7:0]        sync_q;
	hdr_t              res;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        wr_data, rd_data;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Sync byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_q <= cfg_data;
		end
	end

	crc8fp_parse #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.ADDR_W(ADDR_W)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.sync_byte(sync_q),
		.accept(accept),
		.operation(op_t'(s_tuser[0])),
		.rx_byte(s_tdata),
		.res(res),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	crc8fp_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD),
		.ADDR_W(ADDR_W)
	) u_payload_ram (
		.clk(clk),
		.we(wr_en && accept),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	crc8fp_out #(
		.ADDR_W(ADDR_W)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_load(accept),
		.hdr(res),
		.s_ready(s_tready),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

// ----- hdl/crc8fp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crc8fp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/crc8fp_parse.sv -----
// Frame parser: phase machine, running CRC, header registers, payload writes.
module crc8fp_parse import crc8fp_pkg::*; #(
	parameter int MAX_PAYLOAD = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        sync_byte,
	input  logic              accept,
	input  op_t               operation,
	input  logic [7:0]        rx_byte,
	output hdr_t              res,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data
);

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] fill_q, fill_d, fill_inc;
	logic [LEN_W-1:0] exp_q, exp_d;
	logic [7:0]       crc_q, crc_d, crc_next;
	logic [7:0]       src_q, tgt_q, cmd_q;
	logic             hdr_we;
	logic             len_over;

	assign fill_inc = fill_q + 6'd1;
	assign crc_next = crc8_step(crc_q, rx_byte);
	assign len_over = rx_byte > 8'(MAX_PAYLOAD);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (operation == OP_CLEAR) begin
				phase_d = PH_IDLE;
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (rx_byte == sync_byte) phase_d = PH_HEADER;
					end
					PH_HEADER: begin
						if (fill_inc >= HDR_BYTES) begin
							if (len_over) phase_d = PH_ERROR;
							else if (rx_byte == 8'd0) phase_d = PH_CRC;
							else phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						if (fill_inc >= exp_q) phase_d = PH_CRC;
					end
					PH_CRC: begin
						if (crc_q != rx_byte) phase_d = PH_ERROR;
						else phase_d = PH_IDLE;
					end
					default: phase_d = PH_ERROR;
				endcase
			end
		end
	end

	// Datapath updates, payload writes and the result of this request
	always_comb begin
		fill_d  = fill_q;
		exp_d   = exp_q;
		crc_d   = crc_q;
		hdr_we  = 1'b0;
		wr_en   = 1'b0;
		res     = '{status: ST_OK, source_id: 8'd0, dest_id: 8'd0, command: 8'd0,
			payload_len: '0, last: 1'b1};
		if (operation == OP_CLEAR) begin
			fill_d = '0;
			exp_d  = '0;
			crc_d  = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte == sync_byte) begin
						fill_d = '0;
						crc_d  = '0;
					end
				end
				PH_HEADER: begin
					hdr_we = 1'b1;
					crc_d  = crc_next;
					fill_d = fill_inc;
					if (fill_inc >= HDR_BYTES) begin
						if (len_over) begin
							res.status = ST_ERR;
						end else begin
							exp_d  = rx_byte[LEN_W-1:0];
							fill_d = '0;
						end
					end
				end
				PH_DATA: begin
					wr_en  = fill_q < LEN_W'(MAX_PAYLOAD);
					crc_d  = crc_next;
					fill_d = fill_inc;
				end
				PH_CRC: begin
					if (crc_q != rx_byte) begin
						res.status = ST_ERR;
					end else begin
						fill_d          = '0;
						res.status      = ST_FRAME;
						res.source_id   = src_q;
						res.dest_id     = tgt_q;
						res.command     = cmd_q;
						res.payload_len = exp_q;
						res.last        = exp_q == '0;
					end
				end
				default: res.status = ST_ERR;
			endcase
		end
	end

	assign wr_addr = fill_q[ADDR_W-1:0];
	assign wr_data = rx_byte;

	// Control state, advanced on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fill_q  <= '0;
			exp_q   <= '0;
			crc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				fill_q <= fill_d;
				exp_q  <= exp_d;
				crc_q  <= crc_d;
			end
		end
	end

	// Header bytes, written at their position
	always_ff @(posedge clk) begin
		if (accept && hdr_we) begin
			case (fill_q[1:0])
				HDR_SRC: src_q <= rx_byte;
				HDR_TGT: tgt_q <= rx_byte;
				HDR_CMD: cmd_q <= rx_byte;
				default: ;
			endcase
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR && !(accept && operation == OP_CLEAR) |=> phase_q == PH_ERROR)
		else $error("error phase left without a clear");

	a_header_fill: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> fill_q < HDR_BYTES)
		else $error("header fill position out of range");

	a_data_fill: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> fill_q < exp_q)
		else $error("payload fill position past expected length");

endmodule

// ----- hdl/crc8fp_out.sv -----
// Output register and payload readout sequencer over the payload RAM.
module crc8fp_out import crc8fp_pkg::*; #(
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hdr_load,
	input  hdr_t              hdr,
	output logic              s_ready,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	ro_state_t        ro_q, ro_d;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [LEN_W-1:0] k_q, k_inc, len_q;
	logic             out_free;
	logic             data_load;
	logic             k_done;

	assign out_free = !out_valid_q || m_tready;
	assign k_inc    = k_q + 6'd1;
	assign k_done   = k_inc == len_q;

	// Next readout state
	always_comb begin
		ro_d = ro_q;
		case (ro_q)
			RO_RUN: begin
				if (hdr_load && hdr.status == ST_FRAME && hdr.payload_len != '0) ro_d = RO_REQ;
			end
			RO_REQ: ro_d = RO_WAIT;
			RO_WAIT: begin
				if (out_free) ro_d = k_done ? RO_RUN : RO_REQ;
			end
			default: ro_d = RO_RUN;
		endcase
	end

	// Readout controls
	always_comb begin
		s_ready   = (ro_q == RO_RUN) && out_free;
		rd_en     = ro_q == RO_REQ;
		data_load = (ro_q == RO_WAIT) && out_free;
	end

	assign rd_addr = k_q[ADDR_W-1:0];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q        <= RO_RUN;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			len_q       <= '0;
		end else begin
			ro_q <= ro_d;
			if (hdr_load || data_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (hdr_load) begin
				k_q   <= '0;
				len_q <= hdr.payload_len;
			end else if (data_load) begin
				k_q <= k_inc;
			end
		end
	end

	// Output payload: parser result or one payload byte
	always_ff @(posedge clk) begin
		if (hdr_load) begin
			out_q <= '{status: hdr.status, source_id: hdr.source_id,
				dest_id: hdr.dest_id, command: hdr.command,
				payload_len: hdr.payload_len, data_byte: 8'd0, last: hdr.last};
		end else if (data_load) begin
			out_q <= '{status: ST_DATA, source_id: 8'd0, dest_id: 8'd0, command: 8'd0,
				payload_len: '0, data_byte: rd_data, last: k_done};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.data_byte, out_q.payload_len, out_q.command,
		out_q.dest_id, out_q.source_id};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ro_q != RO_RUN |-> k_q < len_q)
		else $error("readout index past payload length");

	a_readout_start: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_load && hdr.status == ST_FRAME && hdr.payload_len != '0 |=> ro_q == RO_REQ)
		else $error("good frame did not start payload readout");

	a_readout_end: assert property (@(posedge clk) disable iff (!arst_n)
		data_load && k_done |=> ro_q == RO_RUN && m_tvalid && m_tlast)
		else $error("final payload byte not marked last");

endmodule
